/* hdl/fst_pkg.sv */
package fst_pkg;

    localparam int ENTRIES = 256;
    localparam int SEQ_LEN = 8;

    // entry index, length slot index and slot counter widths
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
    localparam int KW = $clog2(SEQ_LEN + 1);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
    } t_key;

    typedef struct packed {
        logic [15:0] cnt;
        logic [31:0] bytes;
        logic [63:0] first;
        logic [63:0] last;
    } t_ent;

    typedef struct packed {
        logic        mode;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [15:0] plen;
        logic [63:0] timestamp;
        logic [7:0]  entry_select;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_index;
        logic [31:0] flow_src_ip;
        logic [31:0] flow_dst_ip;
        logic [31:0] flow_ports;
        logic [7:0]  flow_protocol;
        logic [15:0] packet_count;
        logic [31:0] byte_count;
        logic [63:0] duration_ticks;
        logic [2:0]  seq_position;
        logic [15:0] seq_length;
        logic        last;
    } t_out;

    typedef struct packed {
        logic          load_in;
        logic          look;
        logic          rd_entry;
        logic          upd;
        logic          out_status;
        logic          rd_len;
        logic          show_len;
        logic          clear;
        logic [KW-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic full;
        logic empty;
    } t_sts;

endpackage

/* hdl/fst_in_if.sv */
interface fst_in_if;
    logic          valid;
    logic          ready;
    fst_pkg::t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/fst_out_if.sv */
interface fst_out_if;
    logic          valid;
    logic          ready;
    fst_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/fst_ram.sv */
module fst_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                           i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                           o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/fst_ctrl.sv */
module fst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  fst_pkg::t_sts i_sts,
    output fst_pkg::t_cmd o_cmd
);
    import fst_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_LWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [KW-1:0] r_slot, n_slot;
    logic          readout;

    assign readout     = (i_sts.mode == MODE_READ) && !i_sts.empty;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        o_cmd   = '0;
        o_cmd.slot = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.full || i_sts.empty) begin
                    o_cmd.out_status = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_entry = 1'b1;
                    n_slot = '0;
                    n_state = (i_sts.mode == MODE_READ) ? S_LEN : S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_OUT;
            end
            S_LEN: begin
                o_cmd.rd_len = 1'b1;
                n_state = S_LWAIT;
            end
            S_LWAIT: begin
                o_cmd.show_len = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (readout && r_slot != KW'(SEQ_LEN - 1)) begin
                        n_slot  = r_slot + KW'(1);
                        n_state = S_LEN;
                    end else begin
                        o_cmd.clear = readout;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= KW'(SEQ_LEN - 1))
        else $error("slot counter past last length slot");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd || o_cmd.show_len || o_cmd.out_status) |=> o_out_valid)
        else $error("result loaded but not offered");
endmodule

/* hdl/fst_dp.sv */
module fst_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fst_pkg::t_in  i_data,
    input  fst_pkg::t_cmd i_cmd,
    output fst_pkg::t_sts o_sts,
    output fst_pkg::t_out o_data
);
    import fst_pkg::*;

    localparam int LAW = EW + SW;

    t_in           r_in;
    t_key          r_key [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_live;
    logic [EW-1:0] r_e;
    logic          r_hit, r_full, r_empty;
    t_out          r_out;

    t_key          in_key;
    logic          hit, fr, oor;
    logic [EW-1:0] hi, fi, sel;

    t_ent          ent_rd, ent_wr;
    t_key          key_rd;
    logic [15:0]   len_rd;
    logic [15:0]   c;
    logic [32:0]   bsum;
    logic          len_we;
    t_out          stat_out;

    assign in_key = '{src_ip: r_in.src_ip, dst_ip: r_in.dst_ip, sport: r_in.sport,
                      dport: r_in.dport, protocol: r_in.protocol};
    assign sel = EW'(r_in.entry_select);
    assign oor = (32'(r_in.entry_select) >= 32'(ENTRIES));

    // exact match and first free entry, lowest index wins
    always_comb begin
        hit = 1'b0;
        fr  = 1'b0;
        hi  = '0;
        fi  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_key[i] == in_key) begin
                hit = 1'b1;
                hi  = EW'(i);
            end
            if (!r_valid[i]) begin
                fr = 1'b1;
                fi = EW'(i);
            end
        end
    end

    // record update
    always_comb begin
        c    = r_live[r_e] ? ent_rd.cnt : 16'd0;
        bsum = {1'b0, ent_rd.bytes} + {17'd0, r_in.plen};
        ent_wr.last = r_in.timestamp;
        if (c == 16'd0) begin
            ent_wr.first = r_in.timestamp;
            ent_wr.cnt   = 16'd1;
            ent_wr.bytes = {16'd0, r_in.plen};
        end else begin
            ent_wr.first = ent_rd.first;
            ent_wr.cnt   = (c == 16'hFFFF) ? c : c + 16'd1;
            ent_wr.bytes = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
        end
        len_we = i_cmd.upd && (32'(c) < 32'(SEQ_LEN));
    end

    // status-only result: table full or empty readout
    always_comb begin
        stat_out      = '0;
        stat_out.last = 1'b1;
        if (r_full) begin
            stat_out.status = ST_FULL;
        end else begin
            stat_out.status      = ST_EMPTY;
            stat_out.entry_index = r_in.entry_select;
        end
    end

    fst_ram #(.W($bits(t_ent)), .DEPTH(ENTRIES)) u_ent (
        .i_clk(i_clk), .i_we(i_cmd.upd), .i_waddr(r_e), .i_wdata(ent_wr),
        .i_re(i_cmd.rd_entry), .i_raddr(r_e), .o_rdata(ent_rd)
    );

    fst_ram #(.W($bits(t_key)), .DEPTH(ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(i_cmd.upd && !r_hit), .i_waddr(r_e), .i_wdata(in_key),
        .i_re(i_cmd.rd_entry), .i_raddr(r_e), .o_rdata(key_rd)
    );

    fst_ram #(.W(16), .DEPTH(ENTRIES << SW)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(LAW'({r_e, c[SW-1:0]})),
        .i_wdata(r_in.plen), .i_re(i_cmd.rd_len),
        .i_raddr(LAW'({r_e, i_cmd.slot[SW-1:0]})), .o_rdata(len_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live  <= '0;
        end else begin
            if (i_cmd.upd) begin
                r_valid[r_e] <= 1'b1;
                r_live[r_e]  <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_live[r_e] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_data;
        end
        if (i_cmd.upd && !r_hit) begin
            r_key[r_e] <= in_key;
        end
        if (i_cmd.look) begin
            r_e     <= (r_in.mode == MODE_READ) ? sel : (hit ? hi : fi);
            r_hit   <= hit;
            r_full  <= (r_in.mode == MODE_RECORD) && !hit && !fr;
            r_empty <= (r_in.mode == MODE_READ) && (oor || !r_live[sel]);
        end
        if (i_cmd.out_status) begin
            r_out <= stat_out;
        end
        if (i_cmd.upd) begin
            r_out.status         <= ST_OK;
            r_out.entry_index    <= 8'(r_e);
            r_out.flow_src_ip    <= r_in.src_ip;
            r_out.flow_dst_ip    <= r_in.dst_ip;
            r_out.flow_ports     <= {r_in.sport, r_in.dport};
            r_out.flow_protocol  <= r_in.protocol;
            r_out.packet_count   <= ent_wr.cnt;
            r_out.byte_count     <= ent_wr.bytes;
            r_out.duration_ticks <= ent_wr.last - ent_wr.first;
            r_out.seq_position   <= 3'd0;
            r_out.seq_length     <= 16'd0;
            r_out.last           <= 1'b1;
        end
        if (i_cmd.show_len) begin
            r_out.status         <= ST_OK;
            r_out.entry_index    <= 8'(r_e);
            r_out.flow_src_ip    <= key_rd.src_ip;
            r_out.flow_dst_ip    <= key_rd.dst_ip;
            r_out.flow_ports     <= {key_rd.sport, key_rd.dport};
            r_out.flow_protocol  <= key_rd.protocol;
            r_out.packet_count   <= ent_rd.cnt;
            r_out.byte_count     <= ent_rd.bytes;
            r_out.duration_ticks <= ent_rd.last - ent_rd.first;
            r_out.seq_position   <= 3'(i_cmd.slot);
            r_out.seq_length     <= (16'(i_cmd.slot) < ent_rd.cnt) ? len_rd : 16'd0;
            r_out.last           <= (i_cmd.slot == KW'(SEQ_LEN - 1));
        end
    end

    assign o_sts  = '{mode: r_in.mode, full: r_full, empty: r_empty};
    assign o_data = r_out;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live & ~r_valid) == '0)
        else $error("counting entry without a bound key");
    a_upd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> r_live[$past(r_e)])
        else $error("updated entry not counting");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> !r_live[$past(r_e)])
        else $error("read entry not cleared");
endmodule

/* hdl/flow_statistics_table.sv */
// channel | dir | handshake     | payload
// i_in    | in  | valid / ready | mode, 5-tuple, payload length, timestamp, entry_select
// o_out   | out | valid / ready | status, entry and flow fields, seq_position/length, last
//
// One item at a time. A record goes through capture, key match, entry RAM read and
// update to its result; table full and empty readout skip the RAM reads. A readout gives
// SEQ_LEN results, each after a length RAM read, following capture, lookup and entry read.
// The result register holds until taken; input is refused until then.
// Reset (synchronous, active low) clears the key valid and counting bits at once.
module flow_statistics_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fst_in_if.sink    i_in,
    fst_out_if.source o_out
);
    import fst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: handshakes and RAM/update timing
    fst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    // key match array, entry/key/length RAMs and result register
    fst_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_data(i_in.data), .i_cmd(cmd), .o_sts(sts), .o_data(o_out.data)
    );
endmodule

/* tb/sv/tb.sv */
module tb;
    import fst_pkg::*;

    typedef struct {
        t_in data;
        bit  nogap;   // send back to back, no idling on either side
        bit  drain;   // hold off until every result has come back
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    fst_in_if  pkt_ch ();
    fst_out_if res_ch ();

    flow_statistics_table i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pkt_ch.sink),
        .o_out  (res_ch.source)
    );

    // flow table mirror
    bit          ft_bound [ENTRIES];
    t_key        ft_key   [ENTRIES];
    logic [15:0] ft_pkts  [ENTRIES];
    logic [31:0] ft_bytes [ENTRIES];
    logic [63:0] ft_first [ENTRIES];
    logic [63:0] ft_last  [ENTRIES];
    logic [15:0] ft_lens  [ENTRIES][SEQ_LEN];

    t_pending pkt_queue[$];
    t_out     results_due[$];
    t_key     flow_pool[16];

    bit in_taken;
    bit quiet;
    int send_gap;
    int stall_left;
    int n_sent;
    int n_results;
    int n_full;
    int n_empty;
    int n_bad;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d items sent, %0d results due", n_sent, results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // result an entry gives with its current values
    function automatic t_out entry_view(int e, int pos, logic [15:0] len, bit lst);
        t_out r;
        r.status         = ST_OK;
        r.entry_index    = e[7:0];
        r.flow_src_ip    = ft_key[e].src_ip;
        r.flow_dst_ip    = ft_key[e].dst_ip;
        r.flow_ports     = {ft_key[e].sport, ft_key[e].dport};
        r.flow_protocol  = ft_key[e].protocol;
        r.packet_count   = ft_pkts[e];
        r.byte_count     = ft_bytes[e];
        r.duration_ticks = ft_last[e] - ft_first[e];
        r.seq_position   = pos[2:0];
        r.seq_length     = len;
        r.last           = lst;
        return r;
    endfunction

    function automatic t_out status_only(logic [1:0] st, logic [7:0] idx);
        t_out r;
        r             = '0;
        r.status      = st;
        r.entry_index = idx;
        r.last        = 1'b1;
        return r;
    endfunction

    // update the mirror with one accepted item and queue what it yields
    function automatic void flow_update(t_in d);
        t_key        k;
        int          e;
        int          free_e;
        bit          hit;
        logic [32:0] sum;
        logic [15:0] c;
        k      = '{d.src_ip, d.dst_ip, d.sport, d.dport, d.protocol};
        e      = 0;
        free_e = -1;
        hit    = 1'b0;
        if (d.mode == MODE_READ) begin
            e = int'(d.entry_select);
            if (e >= ENTRIES || ft_pkts[e] == 0) begin
                results_due.push_back(status_only(ST_EMPTY, d.entry_select));
                n_empty++;
                return;
            end
            for (int s = 0; s < SEQ_LEN; s++)
                results_due.push_back(entry_view(e, s,
                    (s < ft_pkts[e]) ? ft_lens[e][s] : 16'd0, s == SEQ_LEN - 1));
            ft_pkts[e] = '0;
            return;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (ft_bound[i]) begin
                if (!hit && ft_key[i] == k) begin
                    hit = 1'b1;
                    e   = i;
                end
            end else if (free_e < 0) begin
                free_e = i;
            end
        end
        if (!hit) begin
            if (free_e < 0) begin
                results_due.push_back(status_only(ST_FULL, 8'd0));
                n_full++;
                return;
            end
            e           = free_e;
            ft_bound[e] = 1'b1;
            ft_key[e]   = k;
            ft_pkts[e]  = '0;
        end
        if (ft_pkts[e] == 0) begin
            ft_first[e]   = d.timestamp;
            ft_last[e]    = d.timestamp;
            ft_pkts[e]    = 16'd1;
            ft_bytes[e]   = 32'(d.plen);
            ft_lens[e][0] = d.plen;
        end else begin
            c          = ft_pkts[e];
            ft_last[e] = d.timestamp;
            if (c < SEQ_LEN)
                ft_lens[e][c] = d.plen;
            if (c != 16'hFFFF)
                ft_pkts[e] = c + 16'd1;
            sum         = {1'b0, ft_bytes[e]} + 33'(d.plen);
            ft_bytes[e] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        results_due.push_back(entry_view(e, 0, 16'd0, 1'b1));
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.src_ip   = $urandom;
        k.dst_ip   = $urandom;
        k.sport    = 16'($urandom);
        k.dport    = 16'($urandom);
        k.protocol = 8'($urandom);
        return k;
    endfunction

    function automatic logic [63:0] random_ts();
        return {$urandom, $urandom};
    endfunction

    // record items carry a random entry_select, readouts a random tuple: both ignored
    function automatic void push_record(t_key k, logic [15:0] len, logic [63:0] ts,
                                        bit nogap = 1'b0);
        t_pending p;
        p.data              = '0;
        p.data.mode         = MODE_RECORD;
        p.data.src_ip       = k.src_ip;
        p.data.dst_ip       = k.dst_ip;
        p.data.sport        = k.sport;
        p.data.dport        = k.dport;
        p.data.protocol     = k.protocol;
        p.data.plen         = len;
        p.data.timestamp    = ts;
        p.data.entry_select = 8'($urandom);
        p.nogap             = nogap;
        p.drain             = 1'b0;
        pkt_queue.push_back(p);
    endfunction

    function automatic void push_read(logic [7:0] sel, bit nogap = 1'b0);
        t_pending p;
        t_key     k;
        k = random_key();
        push_record(k, 16'($urandom), random_ts(), nogap);
        p                   = pkt_queue.pop_back();
        p.data.mode         = MODE_READ;
        p.data.entry_select = sel;
        pkt_queue.push_back(p);
    endfunction

    function automatic void push_drain();
        t_pending p;
        p.data  = '0;
        p.nogap = 1'b0;
        p.drain = 1'b1;
        pkt_queue.push_back(p);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // stimulus plan
    initial begin
        t_key ka;
        t_key kb;
        int   r;
        int   p;
        for (int i = 0; i < ENTRIES; i++) begin
            ft_pkts[i]  = '0;
            ft_bytes[i] = '0;
        end
        for (int i = 0; i < 16; i++)
            flow_pool[i] = random_key();
        // reversed direction and protocol-only variants must land in separate entries
        flow_pool[1] = '{flow_pool[0].dst_ip, flow_pool[0].src_ip,
                         flow_pool[0].dport, flow_pool[0].sport, flow_pool[0].protocol};
        flow_pool[2] = flow_pool[0];
        flow_pool[2].protocol = ~flow_pool[0].protocol;
        ka = flow_pool[0];

        // directed: field extremes, duration wrap, clear on read, slot edges
        push_record(ka, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_record(ka, 16'h0000, 64'h0);
        push_read(8'd0);
        push_read(8'd0);
        push_read(8'd255);
        push_record(ka, 16'h1234, 64'h10);
        push_record(flow_pool[1], 16'd7, 64'h20);
        push_record(flow_pool[2], 16'd9, 64'h30);
        push_record('0, 16'd0, 64'h0);
        kb = '1;
        push_record(kb, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 9; i++)
            push_record(flow_pool[3], 16'(i * 1000 + 1), 64'h100 + i);
        push_read(8'd5);
        push_read(8'd0);
        push_read(8'd3);
        push_drain();

        // random: mostly hits on a small pool, some new flows, readouts
        for (int n = 0; n < 20; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                push_record(flow_pool[$urandom_range(0, 15)], 16'($urandom), random_ts());
            else if (r < 75)
                push_record(random_key(), 16'($urandom), random_ts());
            else if (r < 95)
                push_read(8'($urandom_range(0, 23)));
            else
                push_read(8'($urandom));
            if (n == 10)
                push_drain();
        end
        push_drain();

        // fill the table, then misses drop and pool flows still hit
        for (int n = 0; n < 250; n++)
            push_record(random_key(), 16'($urandom), random_ts(), n < 40);
        for (int n = 0; n < 20; n++) begin
            r = $urandom_range(0, 2);
            p = $urandom_range(0, 15);
            if (r == 0)
                push_record(random_key(), 16'($urandom), random_ts());
            else if (r == 1)
                push_record(flow_pool[p], 16'($urandom), random_ts());
            else
                push_read(8'($urandom));
        end
        push_drain();
    end

    // driver
    always @(negedge i_clk) begin
        t_pending head;
        bit       drive;
        if (!i_rst_n) begin
            pkt_ch.valid <= 1'b0;
            pkt_ch.data  <= '0;
        end else if (!pkt_ch.valid || in_taken) begin
            drive = 1'b0;
            while (pkt_queue.size() > 0 && pkt_queue[0].drain && results_due.size() == 0)
                void'(pkt_queue.pop_front());
            if (pkt_queue.size() > 0 && !pkt_queue[0].drain) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    head     = pkt_queue.pop_front();
                    drive    = 1'b1;
                    quiet    = head.nogap;
                    send_gap = head.nogap ? 0 : pick_gap();
                    pkt_ch.data <= head.data;
                end
            end
            pkt_ch.valid <= drive;
        end
    end

    // sink side stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (quiet) begin
            res_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            res_ch.ready <= (stall_left == 0);
        end
    end

    // monitor: predict on accepted items, compare accepted results
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        in_taken <= i_rst_n && pkt_ch.valid && pkt_ch.ready;
        if (i_rst_n && pkt_ch.valid && pkt_ch.ready) begin
            flow_update(pkt_ch.data);
            n_sent++;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            n_results++;
            if (results_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: %p", got);
            end else begin
                want = results_due.pop_front();
                if (want !== got) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pkt_queue.size() == 0 && !pkt_ch.valid);
        wait (results_due.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("%0d packets and readouts sent, %0d results checked", n_sent, n_results);
        $display("table-full drops %0d, empty readouts %0d, table filled to capacity",
                 n_full, n_empty);
        if (n_bad == 0 && results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
